[hw/rtl/bwc_pkg.sv]
// Block witness checker: shared types, constants and the CRC-32C byte step.
package bwc_pkg;

    localparam logic [31:0] CRC32C_POLY_REFL = 32'h82F63B78;
    localparam int unsigned LANE_COUNT       = 4;
    localparam int unsigned BITS_PER_BYTE    = 8;
    localparam int unsigned LANE_W           = $clog2(LANE_COUNT);

    // witness_kind register codes
    localparam logic WK_XOR_FOLD = 1'b0;
    localparam logic WK_CRC32C   = 1'b1;

    // One request as held in the input register
    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        first_of_block;
        logic        first_of_segment;
        logic        last_of_block;
        logic [31:0] expected_witness;
    } t_step;

    typedef struct packed {
        logic [31:0] computed_witness;
        logic        witness_ok;
    } t_result;

    // Reflected CRC-32C over one byte; value kept in finished (inverted) form.
    function automatic logic [31:0] crc_byte_step(input logic [31:0] finished,
                                                  input logic [7:0]  data);
        logic [31:0] crc;
        crc = ~finished ^ {24'd0, data};
        for (int b = 0; b < BITS_PER_BYTE; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC32C_POLY_REFL) : (crc >> 1);
        end
        return ~crc;
    endfunction

endpackage

[hw/rtl/bwc_if.sv]
// Valid/ready stream interfaces for the block witness checker.
interface bwc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        first_of_block;
    logic        first_of_segment;
    logic        last_of_block;
    logic [31:0] expected_witness;

    modport source (output valid, data_byte, has_byte, first_of_block,
                    first_of_segment, last_of_block, expected_witness,
                    input ready);
    modport sink (input valid, data_byte, has_byte, first_of_block,
                  first_of_segment, last_of_block, expected_witness,
                  output ready);
endinterface

interface bwc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] computed_witness;
    logic        witness_ok;

    modport source (output valid, computed_witness, witness_ok, input ready);
    modport sink (input valid, computed_witness, witness_ok, output ready);
endinterface

[hw/rtl/bwc_witness_unit.sv]
// Running witness state and its combinational update per request.
module bwc_witness_unit
    import bwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_kind,
    input  t_step   i_step,
    output t_result o_result
);

    logic [31:0]     r_running, n_running;
    logic [LANE_W-1:0] r_lane, n_lane;
    logic [31:0]     base;
    logic [LANE_W-1:0] lane;
    logic [31:0]     folded;

    always_comb begin
        base = i_step.first_of_block ? 32'd0 : r_running;
        lane = (i_step.first_of_block || i_step.first_of_segment) ? '0 : r_lane;
        folded = base ^ ({24'd0, i_step.data_byte} << ({3'd0, lane} * 5'd8));
        n_running = base;
        n_lane    = lane;
        if (i_step.has_byte) begin
            n_running = (i_kind == WK_CRC32C) ? crc_byte_step(base, i_step.data_byte)
                                              : folded;
            n_lane    = lane + LANE_W'(1);
        end
        o_result.computed_witness = n_running;
        o_result.witness_ok       = (n_running == i_step.expected_witness);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_lane    <= '0;
        end else if (i_step.valid) begin
            r_running <= n_running;
            r_lane    <= n_lane;
        end
    end

endmodule

[hw/rtl/bwc_out_reg.sv]
// Result register driving the output stream.
module bwc_out_reg
    import bwc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_result          i_result,
    output logic             o_busy,
    bwc_out_if.source        o_out
);

    logic    r_valid;
    t_result r_data;

    // busy: a result is held and not taken this cycle
    assign o_busy                 = r_valid && !o_out.ready;
    assign o_out.valid            = r_valid;
    assign o_out.computed_witness = r_data.computed_witness;
    assign o_out.witness_ok       = r_data.witness_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

[hw/rtl/block_witness_checker_core.sv]
// Block witness checker top level: input register, witness update, result register.
// Takes one request per cycle and folds its byte into a 32-bit witness, either
// reflected CRC-32C (inverted init and output, continuous over the whole block)
// or an XOR fold into byte lanes that restart at each segment. A request flagged
// last_of_block yields one result, through the input register and then the
// result register; other requests yield none. The update is a single unrolled 8-bit
// CRC step, so the sustained rate is one request per cycle; input ready drops only in
// reset or while a last request sits in the input register behind an untaken result.
// witness_kind resets to CRC-32C and should be written only while idle.
module block_witness_checker_core
    import bwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    bwc_in_if.sink      i_in,
    bwc_out_if.source   o_out
);

    logic    r_witness_kind;
    t_step   r_in;
    t_step   step;
    t_result result;
    logic    out_busy;
    logic    advance;
    logic    accept;

    assign advance  = r_in.valid && !(r_in.last_of_block && out_busy);
    assign i_in.ready = i_rst_n && (!r_in.valid || advance);
    assign accept   = i_in.valid && i_in.ready;

    always_comb begin
        step       = r_in;
        step.valid = advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_witness_kind <= WK_CRC32C;
        end else if (i_cfg_wr_en) begin
            r_witness_kind <= i_cfg_wr_data;
        end
    end

    // accept is held low in reset, so the payload needs no reset of its own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (accept) begin
            r_in.valid <= 1'b1;
        end else if (advance) begin
            r_in.valid <= 1'b0;
        end
        if (accept) begin
            r_in.data_byte        <= i_in.data_byte;
            r_in.has_byte         <= i_in.has_byte;
            r_in.first_of_block   <= i_in.first_of_block;
            r_in.first_of_segment <= i_in.first_of_segment;
            r_in.last_of_block    <= i_in.last_of_block;
            r_in.expected_witness <= i_in.expected_witness;
        end
    end

    bwc_witness_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kind   (r_witness_kind),
        .i_step   (step),
        .o_result (result)
    );

    bwc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_in.last_of_block),
        .i_result (result),
        .o_busy   (out_busy),
        .o_out    (o_out)
    );

endmodule

[hw/rtl/bwc_checker.sv]
// Port-level checks for the block witness checker, bound to the top level.
module bwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_witness,
    input logic        i_out_ok
);

    // no request taken while in reset
    a_no_ready_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !i_in_ready)
        else $error("input ready high during reset");

    // input only stalls behind a pending result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled without a pending result");

    // a fresh result comes from an earlier accepted request
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching request");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_witness) && $stable(i_out_ok))
        else $error("stalled result changed");

endmodule

bind block_witness_checker_core bwc_checker u_bwc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_witness (o_out.computed_witness),
    .i_out_ok      (o_out.witness_ok)
);

[test/block_witness_checker_core_test.sv]
// Self-checking testbench for block_witness_checker_core: random request stream with scoreboard.
`timescale 1ns / 100ps

module block_witness_checker_core_test;
    import bwc_pkg::*;

    localparam logic [31:0] CASTAGNOLI    = 32'h82F63B78;
    localparam int          IDLE_PCT      = 14;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          MISS_SHOWN    = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        first_of_block;
        logic        first_of_segment;
        logic        last_of_block;
        logic [31:0] expected_witness;
    } t_witness_req;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  lane;
        logic        kind;
    } t_witness_state;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    bwc_in_if  req_if ();
    bwc_out_if res_if ();

    block_witness_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (req_if),
        .o_out         (res_if)
    );

    t_witness_req   req_backlog_q[$];
    t_result        due_witness_q[$];
    t_witness_req   req_on_bus;
    t_witness_state sb_st;      // advanced as requests are accepted
    t_witness_state gen_st;     // advanced as requests are queued
    bit             calm;
    int             hold_arm;
    int             hold_seen;
    int             hold_left;
    int             accepted;
    int             results_seen;
    int             ok_seen;
    int             miss_count;
    int             kind_writes;
    int unsigned    cycle_count;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reflected CRC-32C, one data bit at a time; value held in its finished form
    function automatic logic [31:0] crc32c_fold(input logic [31:0] finished,
                                                input logic [7:0]  b);
        logic [31:0] r;
        r = ~finished;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? CASTAGNOLI : 32'd0);
        end
        return ~r;
    endfunction

    task automatic fold_request(inout t_witness_state st, input t_witness_req r,
                                output bit emits, output t_result res);
        if (r.first_of_block) begin
            st.value = '0;
            st.lane  = '0;
        end
        if (r.first_of_segment) begin
            st.lane = '0;
        end
        if (r.has_byte) begin
            if (st.kind == WK_CRC32C) begin
                st.value = crc32c_fold(st.value, r.data_byte);
            end else begin
                st.value = st.value ^ ({24'd0, r.data_byte} << (8 * st.lane));
            end
            st.lane = st.lane + 2'd1;
        end
        res.computed_witness = st.value;
        res.witness_ok       = (st.value == r.expected_witness);
        emits                = r.last_of_block;
    endtask

    // Queue a request; on a last request optionally pick a matching, near-miss or random witness
    task automatic push_item(input t_witness_req r, input bit pick_expected);
        t_witness_state trial;
        bit             emits;
        t_result        res;
        trial = gen_st;
        fold_request(trial, r, emits, res);
        if (emits && pick_expected) begin
            case ($urandom_range(3))
                0, 1:    r.expected_witness = res.computed_witness;
                2:       r.expected_witness = res.computed_witness ^ (32'd1 << $urandom_range(31));
                default: r.expected_witness = $urandom;
            endcase
        end
        gen_st = trial;
        req_backlog_q.push_back(r);
    endtask

    task automatic put(input logic [7:0] b, input logic has, input logic fob,
                       input logic fos, input logic lob, input logic [31:0] exp_w,
                       input bit pick_expected);
        t_witness_req r;
        r.data_byte        = b;
        r.has_byte         = has;
        r.first_of_block   = fob;
        r.first_of_segment = fos;
        r.last_of_block    = lob;
        r.expected_witness = exp_w;
        push_item(r, pick_expected);
    endtask

    task automatic set_kind(input logic k);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= k;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb_st.kind  = k;
        gen_st.kind = k;
        kind_writes++;
    endtask

    // Wait until every request is taken and every result is back, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (req_backlog_q.size() != 0 || req_if.valid || due_witness_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed blocks of one or two segments; some noise, some broken framing
    task automatic queue_random(input int target, input bit brief);
        t_witness_req r;
        int           made;
        int           seg_a;
        int           total;
        int           mode;
        int           cut;
        bit           broken;
        made = 0;
        while (made < target) begin
            if ($urandom_range(99) < 8) begin
                r.data_byte        = 8'($urandom_range(255));
                r.has_byte         = 1'($urandom_range(1));
                r.first_of_block   = 1'($urandom_range(1));
                r.first_of_segment = 1'($urandom_range(1));
                r.last_of_block    = 1'($urandom_range(1));
                r.expected_witness = $urandom;
                push_item(r, 1'($urandom_range(1)));
                made++;
            end else begin
                if (brief) begin
                    seg_a = $urandom_range(3);
                    total = seg_a + $urandom_range(2);
                end else begin
                    seg_a = ($urandom_range(11) == 0) ? $urandom_range(48, 20)
                                                      : $urandom_range(10);
                    total = seg_a + $urandom_range(6);
                end
                broken = ($urandom_range(99) < 9);
                mode   = $urandom_range(2);
                cut    = (total > 1) ? $urandom_range(total - 2) : 0;
                if (total == 0) begin
                    put(8'($urandom_range(255)), 1'b0, 1'b1, 1'b1, 1'b1, $urandom, 1'b1);
                    made++;
                end
                for (int i = 0; i < total; i++) begin
                    if ($urandom_range(19) == 0) begin
                        put(8'($urandom_range(255)), 1'b0, 1'b0, 1'($urandom_range(1)),
                            1'b0, $urandom, 1'b0);
                    end
                    r.data_byte        = 8'($urandom_range(255));
                    r.has_byte         = 1'b1;
                    r.first_of_block   = (i == 0) && !(broken && mode == 0);
                    r.first_of_segment = (i == 0) || (i == seg_a);
                    r.last_of_block    = (i == total - 1) ? !(broken && mode == 1)
                                                          : (broken && mode == 2 && i == cut);
                    r.expected_witness = $urandom;
                    push_item(r, 1'b1);
                    made++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        bit      emits;
        t_result res;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                accepted++;
                fold_request(sb_st, req_on_bus, emits, res);
                if (emits) begin
                    due_witness_q.push_back(res);
                end
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    req_on_bus = req_backlog_q.pop_front();
                    req_if.data_byte        <= req_on_bus.data_byte;
                    req_if.has_byte         <= req_on_bus.has_byte;
                    req_if.first_of_block   <= req_on_bus.first_of_block;
                    req_if.first_of_segment <= req_on_bus.first_of_segment;
                    req_if.last_of_block    <= req_on_bus.last_of_block;
                    req_if.expected_witness <= req_on_bus.expected_witness;
                    req_if.valid            <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_seen != hold_arm) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_arm;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (res_if.witness_ok) begin
                ok_seen++;
            end
            if (due_witness_q.size() == 0) begin
                if (miss_count < MISS_SHOWN) begin
                    $display("unexpected result: witness %h ok %b",
                             res_if.computed_witness, res_if.witness_ok);
                end
                miss_count++;
            end else begin
                want = due_witness_q.pop_front();
                if (res_if.computed_witness !== want.computed_witness ||
                    res_if.witness_ok !== want.witness_ok) begin
                    if (miss_count < MISS_SHOWN) begin
                        $display("result %0d: witness exp %h got %h, ok exp %b got %b",
                                 results_seen, want.computed_witness,
                                 res_if.computed_witness, want.witness_ok,
                                 res_if.witness_ok);
                    end
                    miss_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog: run still busy after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] xor_bytes [8];
        xor_bytes = '{8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'h11, 8'h22, 8'h33};

        i_rst_n                 = 1'b0;
        i_cfg_wr_en             = 1'b0;
        i_cfg_wr_data           = 1'b0;
        req_if.valid            = 1'b0;
        req_if.data_byte        = '0;
        req_if.has_byte         = 1'b0;
        req_if.first_of_block   = 1'b0;
        req_if.first_of_segment = 1'b0;
        req_if.last_of_block    = 1'b0;
        req_if.expected_witness = '0;
        res_if.ready            = 1'b0;
        sb_st                   = '{32'd0, 2'd0, WK_CRC32C};
        gen_st                  = sb_st;
        calm                    = 1'b0;
        hold_arm                = 0;
        hold_seen               = 0;
        hold_left               = 0;
        accepted                = 0;
        results_seen            = 0;
        ok_seen                 = 0;
        miss_count              = 0;
        kind_writes             = 0;
        cycle_count             = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // CRC-32C out of reset: empty block, check string, all-ones byte, loose framing
        @(negedge i_clk);
        put(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        for (int i = 0; i < 9; i++) begin
            put(8'(8'h31 + i), 1'b1, i == 0, i == 0, i == 8, 32'hE306_9283, 1'b0);
        end
        put(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        put(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, $urandom, 1'b1);      // no block start
        put(8'h7E, 1'b0, 1'b0, 1'b1, 1'b0, $urandom, 1'b0);      // request without a byte
        put(8'h80, 1'b1, 1'b0, 1'b0, 1'b1, $urandom, 1'b1);
        wait_idle();

        // XOR fold: lanes restart on the metadata segment
        set_kind(WK_XOR_FOLD);
        @(negedge i_clk);
        for (int i = 0; i < 8; i++) begin
            put(xor_bytes[i], 1'b1, i == 0, i == 0 || i == 5, i == 7, 32'hDDFF_9955, 1'b0);
        end
        put(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
        put(8'h5A, 1'b1, 1'b1, 1'b1, 1'b0, $urandom, 1'b0);      // left open
        wait_idle();

        // kind switched with the block still open
        set_kind(WK_CRC32C);
        @(negedge i_clk);
        put(8'hA5, 1'b1, 1'b0, 1'b0, 1'b1, $urandom, 1'b1);
        wait_idle();

        set_kind(WK_XOR_FOLD);
        @(negedge i_clk);
        queue_random(300, 1'b0);
        wait_idle();

        set_kind(WK_CRC32C);
        @(negedge i_clk);
        calm = 1'b1;
        queue_random(300, 1'b0);
        wait_idle();
        calm = 1'b0;

        // long sink stall while short blocks keep coming
        set_kind(WK_XOR_FOLD);
        @(negedge i_clk);
        hold_arm++;
        queue_random(150, 1'b1);
        wait_idle();

        set_kind(WK_CRC32C);
        @(negedge i_clk);
        queue_random(250, 1'b0);
        wait_idle();
        queue_random(250, 1'b0);
        wait_idle();

        set_kind(WK_XOR_FOLD);
        @(negedge i_clk);
        queue_random(280, 1'b0);
        wait_idle();

        set_kind(WK_CRC32C);
        @(negedge i_clk);
        queue_random(280, 1'b0);
        wait_idle();
        repeat (10) @(negedge i_clk);

        $display("run: %0d requests accepted, %0d witnesses checked (%0d flagged ok)",
                 accepted, results_seen, ok_seen);
        $display("run: %0d witness-kind writes, both kinds, one %0d-cycle sink stall",
                 kind_writes, HOLD_CYCLES);
        if (miss_count == 0 && due_witness_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     miss_count, due_witness_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
